// ===== sv/fdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// fdcm_pkg
// Shared widths, register map, control types and fixed-point helpers for the
// feedback delay / color / mix echo unit.
// ----------------------------------------------------------------------------
package fdcm_pkg;

    localparam int unsigned SAMPLE_W      = 16;              // Q1.15 samples
    localparam int unsigned COEF_W        = 16;              // Q0.16 coefficients
    localparam int unsigned FRAC_W        = 16;
    localparam int unsigned MCAND_W       = SAMPLE_W + 1;    // sample difference
    localparam int unsigned ACC_W         = 35;
    localparam int unsigned CNT_W         = $clog2(COEF_W);
    localparam int unsigned DEFAULT_DEPTH = 65536;

    localparam int unsigned APB_DATA_W    = 32;
    localparam int unsigned APB_ADDR_W    = 4;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(COEF_W - 1);

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_DELAY    = 2'd0;
    localparam logic [1:0] REG_FEEDBACK = 2'd1;
    localparam logic [1:0] REG_COLOR    = 2'd2;
    localparam logic [1:0] REG_MIX      = 2'd3;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO     = -ACC_W'(32768);

    typedef struct packed {
        logic clear;    // voice start: forget the whole store
        logic wr_en;    // write one sample and read the delayed one
    } fdcm_ring_ctl_t;

    // round to nearest, halves toward +inf, drop the Q0.16 fraction
    function automatic logic signed [ACC_W-1:0] round_q16(input logic signed [ACC_W-1:0] a);
        round_q16 = (a + ROUND_BIAS) >>> FRAC_W;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        if (v > SAT_HI)
        begin
            sat_sample = SAT_HI[SAMPLE_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            sat_sample = SAT_LO[SAMPLE_W-1:0];
        end
        else
        begin
            sat_sample = v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// ===== sv/fdcm_mul.sv =====
// ----------------------------------------------------------------------------
// fdcm_mul
// Bit-serial multiply-accumulate: acc = base + mcand * mplier, with the
// unsigned Q0.16 multiplier shifted out LSB first, one bit per clock.
// ----------------------------------------------------------------------------
module fdcm_mul
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [fdcm_pkg::MCAND_W-1:0]  mcand,
    input  logic        [fdcm_pkg::COEF_W-1:0]   mplier,
    input  logic signed [fdcm_pkg::ACC_W-1:0]    base,
    output logic                                 busy,
    output logic signed [fdcm_pkg::ACC_W-1:0]    acc
);
    import fdcm_pkg::*;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  mcand_reg;
    logic        [COEF_W-1:0] mplier_reg;
    logic        [CNT_W-1:0]  cnt_reg;
    logic                     busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= LAST_STEP;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= base;
            mcand_reg  <= ACC_W'(mcand);
            mplier_reg <= mplier;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

// ===== sv/fdcm_mod.sv =====
// ----------------------------------------------------------------------------
// fdcm_mod
// Restoring remainder of the delay setting by the store depth, one dividend
// bit per clock, MSB first.
// ----------------------------------------------------------------------------
module fdcm_mod
#(
    parameter  int unsigned DEPTH = fdcm_pkg::DEFAULT_DEPTH,
    localparam int unsigned AW    = $clog2(DEPTH)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fdcm_pkg::COEF_W-1:0]   value,
    output logic                          busy,
    output logic [AW-1:0]                 rem
);
    import fdcm_pkg::*;

    localparam logic [AW:0] DEPTH_C = (AW+1)'(DEPTH);

    logic [COEF_W-1:0] val_reg;
    logic [AW-1:0]     rem_reg;
    logic [AW-1:0]     rem_next;
    logic [AW:0]       trial;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;

    always_comb
    begin
        trial = {rem_reg, val_reg[COEF_W-1]};
        if (trial >= DEPTH_C)
        begin
            rem_next = AW'(trial - DEPTH_C);
        end
        else
        begin
            rem_next = trial[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= LAST_STEP;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= value;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= val_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// ===== sv/fdcm_ring.sv =====
// ----------------------------------------------------------------------------
// fdcm_ring
// Delay store with write pointer and fill count. An entry not written since
// the last voice start (or reset) reads as zero; the current write is
// forwarded when the delay is zero.
// ----------------------------------------------------------------------------
module fdcm_ring
#(
    parameter  int unsigned DEPTH = fdcm_pkg::DEFAULT_DEPTH,
    localparam int unsigned AW    = $clog2(DEPTH)
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fdcm_pkg::fdcm_ring_ctl_t              ctl,
    input  logic signed [fdcm_pkg::SAMPLE_W-1:0]  wr_data,
    input  logic        [AW-1:0]                  dly,
    output logic signed [fdcm_pkg::SAMPLE_W-1:0]  delayed
);
    import fdcm_pkg::*;

    localparam logic [AW:0]   DEPTH_C = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];

    logic        [AW-1:0]       pos_reg;
    logic        [AW:0]         fill_reg;
    logic        [AW:0]         fill_next;
    logic        [AW:0]         diff;
    logic        [AW-1:0]       rd_idx;
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic signed [SAMPLE_W-1:0] wr_hold_reg;
    logic                       hit_reg;
    logic                       valid_reg;

    always_comb
    begin
        fill_next = (fill_reg == DEPTH_C) ? fill_reg : fill_reg + 1'b1;
        diff      = {1'b0, pos_reg} - {1'b0, dly};
        if (diff[AW])
        begin
            rd_idx = AW'(diff + DEPTH_C);
        end
        else
        begin
            rd_idx = diff[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else if (ctl.clear)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else if (ctl.wr_en)
        begin
            pos_reg  <= (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[pos_reg] <= wr_data;
            rdata_reg    <= mem[rd_idx];
            wr_hold_reg  <= wr_data;
            hit_reg      <= (dly == '0);
            valid_reg    <= ({1'b0, rd_idx} < fill_next);
        end
    end

    always_comb
    begin
        if (hit_reg)
        begin
            delayed = wr_hold_reg;
        end
        else if (valid_reg)
        begin
            delayed = rdata_reg;
        end
        else
        begin
            delayed = '0;
        end
    end

endmodule

// ===== sv/feedback_delay_color_mix_unit.sv =====
// ----------------------------------------------------------------------------
// feedback_delay_color_mix_unit
// Echo unit: Q1.15 delay line with damped feedback and dry/wet mix.
// ----------------------------------------------------------------------------
// One sample beat is processed at a time, in steps: a bit-serial multiply for
// the feedback term (the delay remainder runs alongside it), a write of the
// store with a read of the delayed sample, a load of the damping and mix
// multipliers, that pair of bit-serial multiplies, round and saturate, then a
// load of the output register once it is free. The next beat is taken after
// that, even while the previous result is still stalled in the output
// register. Voice start clears the store through a fill count, so no clearing
// pass is needed after reset or voice start. Registers are written over APB at
// byte addresses 0 (delay), 4 (feedback), 8 (color) and 12 (mix), using the
// low 16 bits of pwdata.
// ----------------------------------------------------------------------------
module feedback_delay_color_mix_unit
#(
    parameter int unsigned MAX_DELAY_DEPTH = fdcm_pkg::DEFAULT_DEPTH
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [fdcm_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [fdcm_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [fdcm_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  logic signed [fdcm_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic                                   voice_start,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic signed [fdcm_pkg::SAMPLE_W-1:0]   sample_out
);
    import fdcm_pkg::*;

    localparam int unsigned AW = $clog2(MAX_DELAY_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FB   = 5'b00010,
        ST_RD   = 5'b00100,
        ST_MIX  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [COEF_W-1:0] delay_reg;
    logic [COEF_W-1:0] feedback_reg;
    logic [COEF_W-1:0] color_reg;
    logic [COEF_W-1:0] mix_reg;
    logic              cfg_wr;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] last_reg;
    logic signed [SAMPLE_W-1:0] res_reg;
    logic signed [SAMPLE_W-1:0] out_reg;
    logic                       out_valid_reg;

    logic                       accept;
    logic                       fb_start;
    logic                       mix_start;
    logic                       fb_busy;
    logic                       mod_busy;
    logic                       lf_busy;
    logic                       wet_busy;
    logic                       out_load;
    logic                       mix_finish;
    logic signed [ACC_W-1:0]    fb_acc;
    logic signed [ACC_W-1:0]    lf_acc;
    logic signed [ACC_W-1:0]    wet_acc;
    logic signed [MCAND_W-1:0]  fb_mcand;
    logic signed [MCAND_W-1:0]  lf_mcand;
    logic signed [MCAND_W-1:0]  wet_mcand;
    logic signed [ACC_W-1:0]    lf_base;
    logic signed [ACC_W-1:0]    wet_base;
    logic signed [SAMPLE_W-1:0] wr_sample;
    logic signed [SAMPLE_W-1:0] delayed;
    logic        [AW-1:0]       dly_mod;
    fdcm_ring_ctl_t             ring_ctl;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= '0;
            feedback_reg <= '0;
            color_reg    <= '0;
            mix_reg      <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_DELAY:    delay_reg    <= pwdata[COEF_W-1:0];
                REG_FEEDBACK: feedback_reg <= pwdata[COEF_W-1:0];
                REG_COLOR:    color_reg    <= pwdata[COEF_W-1:0];
                REG_MIX:      mix_reg      <= pwdata[COEF_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_DELAY:    prdata = APB_DATA_W'(delay_reg);
            REG_FEEDBACK: prdata = APB_DATA_W'(feedback_reg);
            REG_COLOR:    prdata = APB_DATA_W'(color_reg);
            REG_MIX:      prdata = APB_DATA_W'(mix_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && (state_reg == ST_IDLE);
    assign fb_start   = accept;
    assign mix_start  = (state_reg == ST_RD);
    assign mix_finish = (state_reg == ST_MIX) && !lf_busy && !wet_busy;
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        state_next     = state_reg;
        ring_ctl.clear = accept && voice_start;
        ring_ctl.wr_en = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_FB;
                end
            end
            ST_FB:
            begin
                if (!fb_busy && !mod_busy)
                begin
                    ring_ctl.wr_en = 1'b1;
                    state_next     = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (mix_finish)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && voice_start)
            begin
                last_reg <= '0;
            end
            else if (mix_finish)
            begin
                last_reg <= sat_sample(round_q16(lf_acc));
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= sample_in;
        end
        if (mix_finish)
        begin
            res_reg <= sat_sample(round_q16(wet_acc));
        end
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign sample_out   = out_reg;

    // ---------------- datapath ----------------
    // feedback term from the filter state; cleared state on voice start
    assign fb_mcand  = (voice_start) ? '0 : MCAND_W'(last_reg);
    assign wr_sample = sat_sample(ACC_W'(x_reg) + round_q16(fb_acc));

    // c*last + (1-c)*d  ==  d<<16 + (last - d)*c
    assign lf_mcand  = MCAND_W'(last_reg) - MCAND_W'(delayed);
    assign lf_base   = ACC_W'(delayed) <<< FRAC_W;
    // (1-m)*x + m*d     ==  x<<16 + (d - x)*m
    assign wet_mcand = MCAND_W'(delayed) - MCAND_W'(x_reg);
    assign wet_base  = ACC_W'(x_reg) <<< FRAC_W;

    fdcm_mul u_fb_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fb_start),
        .mcand  (fb_mcand),
        .mplier (feedback_reg),
        .base   ('0),
        .busy   (fb_busy),
        .acc    (fb_acc)
    );

    fdcm_mod #(
        .DEPTH (MAX_DELAY_DEPTH)
    ) u_dly_mod
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (fb_start),
        .value  (delay_reg),
        .busy   (mod_busy),
        .rem    (dly_mod)
    );

    fdcm_ring #(
        .DEPTH (MAX_DELAY_DEPTH)
    ) u_ring
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ring_ctl),
        .wr_data (wr_sample),
        .dly     (dly_mod),
        .delayed (delayed)
    );

    fdcm_mul u_lf_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mix_start),
        .mcand  (lf_mcand),
        .mplier (color_reg),
        .base   (lf_base),
        .busy   (lf_busy),
        .acc    (lf_acc)
    );

    fdcm_mul u_wet_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mix_start),
        .mcand  (wet_mcand),
        .mplier (mix_reg),
        .base   (wet_base),
        .busy   (wet_busy),
        .acc    (wet_acc)
    );

endmodule

// ===== verif/feedback_delay_color_mix_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// feedback_delay_color_mix_unit_tb
// Self-checking bench for the echo unit. Sample beats are driven from a
// queue with random gaps and the result side stalls at random. Each
// accepted beat runs through a local model of the delay line, damping
// filter and mix, and every result is compared against the oldest
// prediction. Registers are rewritten over APB between phases, only once
// the unit has drained: extremes first, then random settings.
// ----------------------------------------------------------------------------
module feedback_delay_color_mix_unit_tb;

    import fdcm_pkg::*;

    localparam int unsigned RING_DEPTH = 65536;
    localparam int unsigned MAX_WAIT   = 13;
    localparam int unsigned DRAIN_GAP  = 40;
    localparam int unsigned RAND_PHASES = 8;
    localparam int unsigned PHASE_BEATS = 116;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       vstart;
    } echo_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [APB_ADDR_W-1:0]       paddr;
    logic [APB_DATA_W-1:0]       pwdata;
    logic [APB_DATA_W-1:0]       prdata;
    logic                        pready;
    logic                        item_valid  = 1'b0;
    logic                        item_stall;
    logic signed [SAMPLE_W-1:0]  sample_in   = '0;
    logic                        voice_start = 1'b0;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]  sample_out;

    // model state and register copies
    logic signed [SAMPLE_W-1:0]  ring_mem [int unsigned];
    int unsigned                 wr_pos    = 0;
    logic signed [SAMPLE_W-1:0]  last_filt = '0;
    logic [COEF_W-1:0]           delay_cfg = '0;
    logic [COEF_W-1:0]           fb_cfg    = '0;
    logic [COEF_W-1:0]           color_cfg = '0;
    logic [COEF_W-1:0]           mix_cfg   = '0;

    echo_beat_t                  pending_beats [$];
    logic signed [SAMPLE_W-1:0]  expected_out_q [$];
    int unsigned                 beats_queued = 0;
    int unsigned                 beats_taken  = 0;
    int unsigned                 err_cnt      = 0;

    int unsigned                 send_gap  = 0;
    int unsigned                 recv_wait = 0;
    bit                          send_calm = 1'b0;
    bit                          recv_calm = 1'b0;
    echo_beat_t                  next_beat;
    logic signed [SAMPLE_W-1:0]  want;

    feedback_delay_color_mix_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .sample_in    (sample_in),
        .voice_start  (voice_start),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_out   (sample_out)
    );

    always #1 clk = ~clk;

    function automatic longint rnd_q16(input longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clip_q15(input longint v);
        if (v > 32767)
        begin
            return 16'sh7fff;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // one beat through the echo path; updates the model state
    function automatic logic signed [SAMPLE_W-1:0] echo_predict(
        input logic signed [SAMPLE_W-1:0] x,
        input logic                       vstart
    );
        longint                     acc;
        int unsigned                rd_pos;
        logic signed [SAMPLE_W-1:0] tap;
        if (vstart)
        begin
            ring_mem.delete();
            wr_pos    = 0;
            last_filt = '0;
        end
        acc = longint'(x) + rnd_q16(longint'(last_filt) * longint'(fb_cfg));
        ring_mem[wr_pos] = clip_q15(acc);
        rd_pos = (wr_pos + RING_DEPTH - int'(delay_cfg)) % RING_DEPTH;
        tap = ring_mem.exists(rd_pos) ? ring_mem[rd_pos] : '0;
        acc = longint'(last_filt) * longint'(color_cfg)
            + longint'(tap) * (64'sd65536 - longint'(color_cfg));
        last_filt = clip_q15(rnd_q16(acc));
        acc = longint'(x) * (64'sd65536 - longint'(mix_cfg))
            + longint'(tap) * longint'(mix_cfg);
        wr_pos = (wr_pos + 1) % RING_DEPTH;
        return clip_q15(rnd_q16(acc));
    endfunction

    function automatic int unsigned draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // sample beat driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid  <= 1'b0;
            sample_in   <= '0;
            voice_start <= 1'b0;
            send_gap     = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                expected_out_q.push_back(echo_predict(sample_in, voice_start));
                beats_taken++;
                if ($urandom_range(0, 31) == 0)
                begin
                    send_calm = !send_calm;
                end
                send_gap = draw_wait(send_calm);
            end
            if (item_valid && item_stall)
            begin
                // hold the stalled beat as is
            end
            else if (send_gap != 0 || pending_beats.size() == 0)
            begin
                item_valid <= 1'b0;
                if (send_gap != 0)
                begin
                    send_gap--;
                end
            end
            else
            begin
                next_beat = pending_beats.pop_front();
                item_valid  <= 1'b1;
                sample_in   <= next_beat.sample;
                voice_start <= next_beat.vstart;
            end
        end
    end

    // result monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            recv_wait     = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_out_q.size() == 0)
                begin
                    $error("sample_out: expected nothing, got %0d", sample_out);
                    err_cnt++;
                end
                else
                begin
                    want = expected_out_q.pop_front();
                    if (sample_out !== want)
                    begin
                        $error("sample_out: expected %0d, got %0d", want, sample_out);
                        err_cnt++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                begin
                    recv_calm = !recv_calm;
                end
                recv_wait = draw_wait(recv_calm);
            end
            else if (result_valid && recv_wait != 0)
            begin
                recv_wait--;
            end
            result_stall <= (recv_wait != 0);
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [COEF_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};   // upper half is ignored by the unit
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DELAY:    delay_cfg = val;
            REG_FEEDBACK: fb_cfg    = val;
            REG_COLOR:    color_cfg = val;
            REG_MIX:      mix_cfg   = val;
            default:      ;
        endcase
    endtask

    task automatic set_regs(input logic [COEF_W-1:0] dly, input logic [COEF_W-1:0] fb,
                            input logic [COEF_W-1:0] col, input logic [COEF_W-1:0] mix);
        apb_write(REG_DELAY, dly);
        apb_write(REG_FEEDBACK, fb);
        apb_write(REG_COLOR, col);
        apb_write(REG_MIX, mix);
    endtask

    task automatic queue_beat(input logic signed [SAMPLE_W-1:0] s, input logic vs);
        echo_beat_t b;
        b.sample = s;
        b.vstart = vs;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // sender holds off here until every result is back
    task automatic wait_drained();
        do @(posedge clk);
        while (beats_taken != beats_queued || expected_out_q.size() != 0);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'hffff;
            2:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hffff;
            2:       return 16'($urandom);
            3, 4:    return 16'($urandom_range(0, 900));
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(0, 511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: dry path only
        queue_beat(16'sh7fff, 1'b0);
        queue_beat(16'sh8000, 1'b0);
        queue_beat(16'sh0000, 1'b1);
        queue_beat(-16'sd1, 1'b0);
        wait_drained();

        // no delay, full feedback, wet only: the write saturates both ways
        set_regs(16'd0, 16'hffff, 16'd0, 16'hffff);
        repeat (3) queue_beat(16'sh7fff, 1'b0);
        repeat (3) queue_beat(16'sh8000, 1'b0);
        wait_drained();

        // short delay, heavy damping, voice start in the middle
        set_regs(16'd2, 16'h8000, 16'hffff, 16'h8000);
        queue_beat(16'sd1000, 1'b0);
        queue_beat(-16'sd1000, 1'b0);
        queue_beat(16'sd0, 1'b0);
        queue_beat(16'sd0, 1'b0);
        queue_beat(16'sd0, 1'b0);
        queue_beat(16'sd12345, 1'b1);
        queue_beat(16'sd0, 1'b0);
        queue_beat(16'sd0, 1'b0);
        wait_drained();

        // longest delay: the read wraps behind the write pointer
        set_regs(16'hffff, 16'd0, 16'd40000, 16'hffff);
        queue_beat(16'sh7fff, 1'b0);
        queue_beat(16'sh8000, 1'b0);
        queue_beat(16'sh5555, 1'b0);
        queue_beat(-16'sh2aab, 1'b0);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            set_regs(pick_delay(), pick_coef(), pick_coef(), pick_coef());
            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                queue_beat(pick_sample(), ($urandom_range(0, 39) == 0));
            end
            wait_drained();
        end

        if (err_cnt == 0 && expected_out_q.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
